/* hw/rtl/cna_pkg.sv */
// ----------------------------------------------------------------------------
// cna_pkg: shared types and constants of the chunked node allocator
// widths, status and request codes, configuration register map and layout
// ----------------------------------------------------------------------------
package cna_pkg;

  localparam int THREADS     = 8;
  localparam int THR_W       = $clog2(THREADS);
  localparam int TID_W       = 4;
  localparam int CHUNK_LOG2  = 16;
  localparam int STACK_DEPTH = 16;
  localparam int STK_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W     = $clog2(THREADS * STACK_DEPTH);
  localparam int ADDR_BITS   = 48;
  localparam int AW2         = ADDR_BITS + 2;   // room for carries past the top
  localparam int SAO_W       = 16;
  localparam int NPC_W       = 14;
  localparam int ALIGN_W     = 17;
  localparam int TOTAL_W     = 17;
  localparam int OCC_W       = 21;
  localparam int STATUS_W    = 3;
  localparam int REQ_W       = 2;

  // stream layout
  localparam int IN_BITS    = TID_W + 2 * ADDR_BITS + ALIGN_W;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ADDR_BITS + STATUS_W + OCC_W;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [ADDR_BITS-1:0] SPACE_LIMIT_RST = {ADDR_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] START_OFFSET_RST = ADDR_BITS'(4096);
  localparam logic [SAO_W-1:0]     SAO_RST = '0;
  localparam logic [NPC_W-1:0]     NPC_RST = NPC_W'(8192);
  localparam logic [ADDR_BITS-1:0] NIL_RST = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC_NODE = 2'd0,
    REQ_FREE_NODE  = 2'd1,
    REQ_ALLOC_DATA = 2'd2,
    REQ_RESERVED   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_THREAD  = 3'd1,
    ST_BAD_ALIGN   = 3'd2,
    ST_NO_SPACE    = 3'd3,
    ST_NIL_IGNORED = 3'd4,
    ST_STACK_FULL  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_SPACE_LIMIT  = 3'd0,
    REG_START_OFFSET = 3'd1,
    REG_SLOT_OFFSET  = 3'd2,
    REG_NODES_CHUNK  = 3'd3,
    REG_NIL_HANDLE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] space_limit;
    logic [ADDR_BITS-1:0] start_offset;
    logic [SAO_W-1:0]     slot_array_offset;
    logic [NPC_W-1:0]     slots_per_chunk;
    logic [ADDR_BITS-1:0] nil_handle;
  } cfg_t;

endpackage

/* hw/rtl/cna_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cna_cfg_regs: configuration registers of the chunked node allocator
// apb-style register file, 64-bit registers at byte address 8*index
// ----------------------------------------------------------------------------
module cna_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cna_pkg::PADDR_W-1:0]  paddr,
  input  logic [cna_pkg::PDATA_W-1:0]  pwdata,
  output logic [cna_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cna_pkg::cfg_t                cfg,
  output logic                         start_load
);
  import cna_pkg::*;

  logic     wr;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_limit       <= SPACE_LIMIT_RST;
      cfg.start_offset      <= START_OFFSET_RST;
      cfg.slot_array_offset <= SAO_RST;
      cfg.slots_per_chunk   <= NPC_RST;
      cfg.nil_handle        <= NIL_RST;
      start_load            <= 1'b0;
    end else begin
      start_load <= 1'b0;
      if (wr) begin
        unique case (reg_idx)
          REG_SPACE_LIMIT: cfg.space_limit <= pwdata[ADDR_BITS-1:0];
          REG_START_OFFSET: begin
            cfg.start_offset <= pwdata[ADDR_BITS-1:0];
            start_load       <= 1'b1;
          end
          REG_SLOT_OFFSET: cfg.slot_array_offset <= pwdata[SAO_W-1:0];
          REG_NODES_CHUNK: cfg.slots_per_chunk   <= pwdata[NPC_W-1:0];
          REG_NIL_HANDLE:  cfg.nil_handle        <= pwdata[ADDR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPACE_LIMIT:  prdata = PDATA_W'(cfg.space_limit);
      REG_START_OFFSET: prdata = PDATA_W'(cfg.start_offset);
      REG_SLOT_OFFSET:  prdata = PDATA_W'(cfg.slot_array_offset);
      REG_NODES_CHUNK:  prdata = PDATA_W'(cfg.slots_per_chunk);
      REG_NIL_HANDLE:   prdata = PDATA_W'(cfg.nil_handle);
      default:          prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/chunked_node_allocator_top.sv */
// ----------------------------------------------------------------------------
// chunked_node_allocator_top: node and data-chunk allocator over one offset space
// per-thread chunk bump allocation with per-thread recycle stacks
// ----------------------------------------------------------------------------
// One request in, one result out, in order. A node allocate pops the thread's
// recycle stack when it holds entries, otherwise it hands out the next 8-byte
// slot of the thread's chunk, carving a fresh 64 KiB aligned chunk from the
// global bump pointer when the thread has none or its chunk is used up (at
// most two carves per request; carved chunks stay even when the result is
// out of space). A free pushes a handle on the thread's stack; a data-chunk
// request bump-allocates any size at a power-of-two alignment. Every result
// carries the occupied bytes, 18 per node slot in use. The block sustains one
// transfer per clock while the result stream is not stalled: all per-thread
// state and the bump pointer are read, updated and written back in the cycle
// an item leaves the input register, so the next item sees it at once. A
// result passes from the input register through the result stage, where the
// stack read lands, to the output register. The recycle stacks sit in a
// memory with a registered read port and need no clearing after reset: an
// entry is only ever read after it was pushed. Configuration writes are
// expected while no request is in flight; a write of start_offset also
// reloads the bump pointer in the following cycle.
module chunked_node_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata from bit 0: thread, handle to free, data size, alignment, zero fill
  input  logic [cna_pkg::S_TDATA_W-1:0]  s_tdata,
  // tuser: req_type
  input  logic [cna_pkg::REQ_W-1:0]      s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata from bit 0: handle, status, occupied_bytes, zero fill
  output logic [cna_pkg::M_TDATA_W-1:0]  m_tdata,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cna_pkg::PADDR_W-1:0]    paddr,
  input  logic [cna_pkg::PDATA_W-1:0]    pwdata,
  output logic [cna_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import cna_pkg::*;

  localparam logic [AW2-1:0] ADDR_MAX   = AW2'({ADDR_BITS{1'b1}});
  localparam logic [AW2-1:0] CHUNK_SIZE = AW2'(1) << CHUNK_LOG2;
  localparam logic [AW2-1:0] CHUNK_MASK = CHUNK_SIZE - AW2'(1);

  cfg_t cfg;
  logic start_load;

  cna_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .start_load (start_load)
  );

  // allocator state
  logic [ADDR_BITS-1:0] bump_ptr;
  logic [ADDR_BITS-1:0] chunk_base [THREADS];
  logic [NPC_W-1:0]     slots_used [THREADS];
  logic [DEPTH_W-1:0]   depth      [THREADS];
  logic [TOTAL_W-1:0]   total;
  logic [ADDR_BITS-1:0] stack_mem  [THREADS*STACK_DEPTH];
  logic [ADDR_BITS-1:0] stack_rdata;

  // input register
  logic                 s1_valid;
  req_t                 s1_req;
  logic [TID_W-1:0]     s1_tid;
  logic [ADDR_BITS-1:0] s1_nh;
  logic [ADDR_BITS-1:0] s1_size;
  logic [ALIGN_W-1:0]   s1_align;

  // result stage
  logic                 s2_valid;
  logic [ADDR_BITS-1:0] s2_handle;
  status_t              s2_status;
  logic                 s2_pop;
  logic [TOTAL_W-1:0]   s2_total;

  // output register
  logic [ADDR_BITS-1:0] m_handle;
  logic [STATUS_W-1:0]  m_status;
  logic [OCC_W-1:0]     m_occ;

  logic adv1;
  logic adv2;

  // per-request work
  logic [THR_W-1:0]     t;
  logic                 bad_t;
  logic [ADDR_BITS-1:0] cur_base;
  logic [NPC_W-1:0]     cur_used;
  logic [DEPTH_W-1:0]   cur_depth;
  logic                 cur_ok;
  logic [AW2-1:0]       lim;
  logic [AW2-1:0]       c_up;
  logic [AW2-1:0]       c1_base;
  logic [AW2-1:0]       c1_next;
  logic [AW2-1:0]       c2_next;
  logic                 c1_ok;
  logic                 c2_ok;
  logic                 fresh_ok;
  logic [ALIGN_W-1:0]   align_m;
  logic                 align_ok;
  logic [AW2-1:0]       d_up;
  logic [AW2-1:0]       d_base;
  logic [AW2-1:0]       d_next;
  logic                 d_ok;
  logic [ADDR_BITS-1:0] slot_base;
  logic [NPC_W-1:0]     slot_idx;
  logic [ADDR_BITS-1:0] slot_handle;
  logic [SADDR_W-1:0]   push_addr;
  logic [SADDR_W-1:0]   pop_addr;

  // next values
  logic [ADDR_BITS-1:0] res_handle;
  status_t              res_status;
  logic                 pop_rd;
  logic                 push_we;
  logic                 bump_we;
  logic [ADDR_BITS-1:0] bump_next;
  logic                 thr_we;
  logic [ADDR_BITS-1:0] base_next;
  logic [NPC_W-1:0]     used_next;
  logic                 depth_we;
  logic [DEPTH_W-1:0]   depth_next;
  logic [TOTAL_W-1:0]   total_next;
  logic [TOTAL_W+4:0]   occ_calc;

  // pipeline flow
  assign adv2     = s2_valid & (~m_tvalid | m_tready);
  assign adv1     = s1_valid & (~s2_valid | adv2);
  assign s_tready = ~s1_valid | adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_req   <= req_t'(s_tuser);
      s1_tid   <= s_tdata[TID_W-1:0];
      s1_nh    <= s_tdata[TID_W +: ADDR_BITS];
      s1_size  <= s_tdata[TID_W+ADDR_BITS +: ADDR_BITS];
      s1_align <= s_tdata[TID_W+2*ADDR_BITS +: ALIGN_W];
    end
  end

  // thread view
  assign t         = s1_tid[THR_W-1:0];
  assign bad_t     = s1_tid >= TID_W'(THREADS);
  assign cur_base  = chunk_base[t];
  assign cur_used  = slots_used[t];
  assign cur_depth = depth[t];
  assign cur_ok    = (cur_base != '0) && (cur_used < cfg.slots_per_chunk);
  assign lim       = AW2'(cfg.space_limit);

  // chunk carve: first chunk at the aligned bump pointer, second right after it
  assign c_up     = AW2'(bump_ptr) + CHUNK_MASK;
  assign c1_base  = c_up & ~CHUNK_MASK;
  assign c1_next  = c1_base + CHUNK_SIZE;
  assign c2_next  = c1_base + (CHUNK_SIZE << 1);
  assign c1_ok    = (c_up <= ADDR_MAX) && (c1_next <= ADDR_MAX) && (c1_next <= lim);
  assign c2_ok    = c1_ok && (c2_next <= ADDR_MAX) && (c2_next <= lim);
  // a chunk at offset zero counts as no chunk
  assign fresh_ok = (c1_base[ADDR_BITS-1:0] != '0) && (cfg.slots_per_chunk != '0);

  // data chunk
  assign align_m  = s1_align - ALIGN_W'(1);
  assign align_ok = (s1_align != '0) && ((s1_align & align_m) == '0);
  assign d_up     = AW2'(bump_ptr) + AW2'(align_m);
  assign d_base   = d_up & ~AW2'(align_m);
  assign d_next   = d_base + AW2'(s1_size);
  assign d_ok     = (d_up <= ADDR_MAX) && (d_next <= ADDR_MAX) && (d_next <= lim);

  // slot handle, wraps at the address width
  assign slot_base   = cur_ok ? cur_base : c1_base[ADDR_BITS-1:0];
  assign slot_idx    = cur_ok ? cur_used : '0;
  assign slot_handle = slot_base + ADDR_BITS'(cfg.slot_array_offset)
                     + ADDR_BITS'({slot_idx, 3'b000});

  assign push_addr = SADDR_W'(t) * SADDR_W'(STACK_DEPTH) + SADDR_W'(cur_depth);
  assign pop_addr  = SADDR_W'(t) * SADDR_W'(STACK_DEPTH) + SADDR_W'(depth_next);

  always_comb begin
    res_handle = '0;
    res_status = ST_OK;
    pop_rd     = 1'b0;
    push_we    = 1'b0;
    bump_we    = 1'b0;
    bump_next  = bump_ptr;
    thr_we     = 1'b0;
    base_next  = cur_base;
    used_next  = cur_used;
    depth_we   = 1'b0;
    depth_next = cur_depth - DEPTH_W'(1);
    total_next = total;
    case (s1_req)
      REQ_ALLOC_NODE: begin
        if (bad_t) begin
          res_status = ST_BAD_THREAD;
        end else if (cur_depth != '0) begin
          // recycled handle comes out of the stack memory in the result stage
          pop_rd   = 1'b1;
          depth_we = 1'b1;
        end else if (cur_ok) begin
          res_handle = slot_handle;
          thr_we     = 1'b1;
          used_next  = cur_used + NPC_W'(1);
          total_next = total + TOTAL_W'(1);
        end else if (!c1_ok) begin
          res_status = ST_NO_SPACE;
        end else if (fresh_ok) begin
          res_handle = slot_handle;
          bump_we    = 1'b1;
          bump_next  = c1_next[ADDR_BITS-1:0];
          thr_we     = 1'b1;
          base_next  = c1_base[ADDR_BITS-1:0];
          used_next  = NPC_W'(1);
          total_next = total - TOTAL_W'(cur_used) + TOTAL_W'(1);
        end else if (!c2_ok) begin
          // first carve kept, second failed
          res_status = ST_NO_SPACE;
          bump_we    = 1'b1;
          bump_next  = c1_next[ADDR_BITS-1:0];
          thr_we     = 1'b1;
          base_next  = c1_base[ADDR_BITS-1:0];
          used_next  = '0;
          total_next = total - TOTAL_W'(cur_used);
        end else begin
          // both carves taken, retry budget spent
          res_status = ST_NO_SPACE;
          bump_we    = 1'b1;
          bump_next  = c2_next[ADDR_BITS-1:0];
          thr_we     = 1'b1;
          base_next  = c1_next[ADDR_BITS-1:0];
          used_next  = '0;
          total_next = total - TOTAL_W'(cur_used);
        end
      end
      REQ_FREE_NODE: begin
        if (s1_nh == cfg.nil_handle) begin
          res_status = ST_NIL_IGNORED;
        end else if (bad_t) begin
          res_status = ST_BAD_THREAD;
        end else if (cur_depth >= DEPTH_W'(STACK_DEPTH)) begin
          res_status = ST_STACK_FULL;
        end else begin
          push_we    = 1'b1;
          depth_we   = 1'b1;
          depth_next = cur_depth + DEPTH_W'(1);
        end
      end
      REQ_ALLOC_DATA: begin
        if (!align_ok) begin
          res_status = ST_BAD_ALIGN;
        end else if (!d_ok) begin
          res_status = ST_NO_SPACE;
        end else begin
          res_handle = d_base[ADDR_BITS-1:0];
          bump_we    = 1'b1;
          bump_next  = d_next[ADDR_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // state update, once per item leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      bump_ptr <= START_OFFSET_RST;
      total    <= '0;
      for (int i = 0; i < THREADS; i++) begin
        chunk_base[i] <= '0;
        slots_used[i] <= '0;
        depth[i]      <= '0;
      end
    end else begin
      if (start_load) begin
        bump_ptr <= cfg.start_offset;
      end else if (adv1 && bump_we) begin
        bump_ptr <= bump_next;
      end
      if (adv1) begin
        total <= total_next;
        if (thr_we) begin
          chunk_base[t] <= base_next;
          slots_used[t] <= used_next;
        end
        if (depth_we) begin
          depth[t] <= depth_next;
        end
      end
    end
  end

  // recycle stack memory
  always_ff @(posedge clk) begin
    if (adv1 && push_we) begin
      stack_mem[push_addr] <= s1_nh;
    end
    if (adv1 && pop_rd) begin
      stack_rdata <= stack_mem[pop_addr];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv1) begin
      s2_valid <= 1'b1;
    end else if (adv2) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_handle <= res_handle;
      s2_status <= res_status;
      s2_pop    <= pop_rd;
      s2_total  <= total_next;
    end
  end

  // occupied bytes: total * 18 as two shifted adds
  assign occ_calc = {1'b0, s2_total, 4'b0000} + {4'b0000, s2_total, 1'b0};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      m_handle <= s2_pop ? stack_rdata : s2_handle;
      m_status <= s2_status;
      m_occ    <= occ_calc[OCC_W-1:0];
    end
  end

  assign m_tdata = M_TDATA_W'({m_occ, m_status, m_handle});

  // bump pointer only moves forward while serving requests
  assert property (@(posedge clk) disable iff (rst)
    adv1 |=> (bump_ptr >= $past(bump_ptr)) || $past(start_load))
    else $error("bump pointer moved backward");

  // a failed request never hands out an offset
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_status != ST_OK) |-> (m_handle == '0))
    else $error("nonzero handle with error status");

  // a pop only happens from a non-empty stack
  assert property (@(posedge clk) disable iff (rst)
    adv1 && pop_rd |-> (cur_depth != '0) && !push_we)
    else $error("pop from empty recycle stack");

  // a stalled result stage keeps its contents and blocks the input register
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !adv2 |=> s2_valid && $stable(s2_handle)
                          && (!s2_pop || $stable(stack_rdata)))
    else $error("result stage lost data while stalled");

endmodule
